// ===== sv/hufc_pkg.sv =====
// shared constants for the huffman table codec
// opcodes, result kinds and parameter defaults; no dependencies
package hufc_pkg;

	localparam int MAX_CODE_LEN_DEF = 16;
	localparam int SYMBOL_COUNT_DEF = 256;

	localparam int CODE_W   = 16; // width of the code_bits field
	localparam int BYTE_W   = 8;
	localparam int OP_W     = 2;
	localparam int KIND_W   = 2;
	localparam int LENIN_W  = 5;
	localparam int S_DATA_W = 40; // request fields packed and padded to bytes

	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
	localparam logic [OP_W-1:0] OP_DECODE = 2'd2;
	localparam logic [OP_W-1:0] OP_END    = 2'd3;

	localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

endpackage

// ===== sv/huffman_table_codec_core.sv =====
// huffman table codec: code table memory, byte packer and bitwise decoder
// depends on hufc_pkg
//
// Table-driven Huffman codec. A load request writes one code table entry (code value,
// length; length zero means absent) and yields no result. An encode request reads the
// entry of its symbol and shifts the code MSB-first into the byte packer, one bit per
// cycle while no byte result waits to be emitted, giving a byte result for every full
// byte; absent symbols shift eight zero bits. An end request zero-pads and gives any
// partial byte and clears the partial decode code. A decode request shifts its byte in
// MSB-first; after each bit the table memory is scanned from symbol 0 upward, each entry
// read and then compared, and the first entry of matching length and value gives a
// symbol result. A code that reaches MAX_CODE_LEN bits unmatched gives an error result.
// Decode time is set by the single read port of the table memory; result backpressure
// stalls the sequencer. Each result is held one step so that the final result of a
// request carries tlast. Table entries reset to absent through per-entry valid flops,
// no clearing pass.
module huffman_table_codec_core #(
	parameter int MAX_CODE_LEN = hufc_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hufc_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// symbol[7:0], code_bits[23:8], code_length[28:24], data_byte[36:29], zero pad
	input  logic [hufc_pkg::S_DATA_W-1:0] s_tdata,
	// opcode[1:0]
	input  logic [hufc_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// value[7:0]
	output logic [hufc_pkg::BYTE_W-1:0]   m_tdata,
	// kind[1:0]
	output logic [hufc_pkg::KIND_W-1:0]   m_tuser,
	output logic                          m_tlast
);

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int CMP_W = (MAX_CODE_LEN > hufc_pkg::CODE_W) ? MAX_CODE_LEN : hufc_pkg::CODE_W;
	localparam int IDX_W = $clog2(CMP_W);
	localparam int SYM_W = $clog2(SYMBOL_COUNT);
	localparam int ENT_W = hufc_pkg::CODE_W + LEN_W;
	localparam int CNT_W = $clog2(hufc_pkg::BYTE_W + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_ENC_LD    = 3'd1;
	localparam logic [2:0] ST_ENC_BIT   = 3'd2;
	localparam logic [2:0] ST_DEC_SHIFT = 3'd3;
	localparam logic [2:0] ST_DEC_RD    = 3'd4;
	localparam logic [2:0] ST_DEC_CMP   = 3'd5;
	localparam logic [2:0] ST_EMIT      = 3'd6;
	localparam logic [2:0] ST_FLUSH     = 3'd7;

	// request fields
	logic [7:0]                   in_symbol;
	logic [hufc_pkg::CODE_W-1:0]  in_code;
	logic [hufc_pkg::LENIN_W-1:0] in_len;
	logic [7:0]                   in_byte;
	assign in_symbol = s_tdata[7:0];
	assign in_code   = s_tdata[23:8];
	assign in_len    = s_tdata[28:24];
	assign in_byte   = s_tdata[36:29];

	logic [2:0] state_q, ret_q;

	// code table memory, valid flops stand for the reset-to-absent
	logic [ENT_W-1:0]        tbl_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] tbl_vld_q;
	logic [ENT_W-1:0]        rd_s1;
	logic                    rd_vld_s1;
	logic [SYM_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [SYM_W-1:0]        wr_addr;
	logic [ENT_W-1:0]        wr_data;

	// packer and decoder state
	logic [6:0]              pack_bits_q;
	logic [2:0]              pack_count_q;
	logic [MAX_CODE_LEN-1:0] match_code_q;
	logic [LEN_W-1:0]        match_len_q;

	// per-request working registers
	logic [CMP_W-1:0]        enc_code_q;
	logic [LEN_W-1:0]        enc_cnt_q;
	logic                    sym_ok_q;
	logic [7:0]              dec_byte_q;
	logic [CNT_W-1:0]        dec_cnt_q;
	logic [SYM_W-1:0]        scan_q;

	// result staging: new result, pending result, output register
	logic [hufc_pkg::KIND_W-1:0] new_kind_q, pend_kind_q, out_kind_q;
	logic [7:0]                  new_val_q, pend_val_q, out_val_q;
	logic                        pend_vld_q, out_vld_q, out_last_q;

	logic out_free;
	assign out_free = !out_vld_q || m_tready;

	// pending result moves into the output register this cycle
	logic out_load;
	assign out_load = pend_vld_q && out_free
		&& ((state_q == ST_EMIT) || (state_q == ST_FLUSH));

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	logic sym_ok;
	assign sym_ok = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));

	// load entry: saturated length, code masked to that length
	logic [LEN_W-1:0]            ld_len;
	logic [hufc_pkg::CODE_W-1:0] ld_code;
	always_comb begin
		if (int'(in_len) > MAX_CODE_LEN) begin
			ld_len = LEN_W'(MAX_CODE_LEN);
		end else begin
			ld_len = LEN_W'(in_len);
		end
		for (int i = 0; i < hufc_pkg::CODE_W; i++) begin
			ld_code[i] = in_code[i] && (i < int'(ld_len));
		end
	end

	assign wr_en   = accept && (s_tuser == hufc_pkg::OP_LOAD) && sym_ok;
	assign wr_addr = in_symbol[SYM_W-1:0];
	assign wr_data = {ld_code, ld_len};
	assign rd_addr = (state_q == ST_IDLE) ? in_symbol[SYM_W-1:0] : scan_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= wr_data;
		end
		rd_s1 <= tbl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				tbl_vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= tbl_vld_q[rd_addr];
		end
	end

	// fields of the entry just read, absent when never written
	logic [LEN_W-1:0]            ent_len;
	logic [hufc_pkg::CODE_W-1:0] ent_code;
	assign ent_len  = rd_vld_s1 ? rd_s1[LEN_W-1:0] : '0;
	assign ent_code = rd_s1[ENT_W-1:LEN_W];

	// encode bit and packer next values
	logic       enc_bit;
	logic [7:0] pack_full;
	assign enc_bit   = enc_code_q[IDX_W'(enc_cnt_q - 1'b1)];
	assign pack_full = {pack_bits_q, enc_bit};

	logic [7:0] end_byte;
	assign end_byte = 8'({pack_bits_q, 1'b0} << (3'd7 - pack_count_q));

	// decode compare
	logic                    dec_bit;
	logic                    hit;
	logic                    scan_last;
	logic [LEN_W-1:0]        dec_after;
	assign dec_bit   = dec_byte_q[7];
	assign hit       = (ent_len != '0) && (ent_len == match_len_q)
		&& (CMP_W'(ent_code) == CMP_W'(match_code_q));
	assign scan_last = (scan_q == SYM_W'(SYMBOL_COUNT - 1));
	assign dec_after = '0;

	logic [2:0] dec_next;
	assign dec_next = (dec_cnt_q == '0) ? ST_FLUSH : ST_DEC_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= ST_IDLE;
			pack_bits_q  <= '0;
			pack_count_q <= '0;
			match_code_q <= '0;
			match_len_q  <= '0;
			enc_code_q   <= '0;
			enc_cnt_q    <= '0;
			sym_ok_q     <= 1'b0;
			dec_byte_q   <= '0;
			dec_cnt_q    <= '0;
			scan_q       <= '0;
			new_kind_q   <= '0;
			new_val_q    <= '0;
			pend_kind_q  <= '0;
			pend_val_q   <= '0;
			out_kind_q   <= '0;
			out_val_q    <= '0;
			out_last_q   <= 1'b0;
			pend_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							hufc_pkg::OP_ENCODE: begin
								sym_ok_q <= sym_ok;
								state_q  <= ST_ENC_LD;
							end
							hufc_pkg::OP_DECODE: begin
								dec_byte_q <= in_byte;
								dec_cnt_q  <= CNT_W'(8);
								state_q    <= ST_DEC_SHIFT;
							end
							hufc_pkg::OP_END: begin
								match_code_q <= '0;
								match_len_q  <= dec_after;
								if (pack_count_q != '0) begin
									new_kind_q   <= hufc_pkg::KIND_BYTE;
									new_val_q    <= end_byte;
									pack_bits_q  <= '0;
									pack_count_q <= '0;
									ret_q        <= ST_FLUSH;
									state_q      <= ST_EMIT;
								end else begin
									state_q <= ST_FLUSH;
								end
							end
							default: begin
								// load: table written above, no result
							end
						endcase
					end
				end
				ST_ENC_LD: begin
					// absent or out-of-range symbol shifts eight zero bits
					if (sym_ok_q && ent_len != '0) begin
						enc_code_q <= CMP_W'(ent_code);
						enc_cnt_q  <= ent_len;
					end else begin
						enc_code_q <= '0;
						enc_cnt_q  <= LEN_W'(8);
					end
					state_q <= ST_ENC_BIT;
				end
				ST_ENC_BIT: begin
					enc_cnt_q <= enc_cnt_q - 1'b1;
					if (pack_count_q == 3'd7) begin
						pack_bits_q  <= '0;
						pack_count_q <= '0;
						new_kind_q   <= hufc_pkg::KIND_BYTE;
						new_val_q    <= pack_full;
						ret_q        <= (enc_cnt_q == LEN_W'(1)) ? ST_FLUSH : ST_ENC_BIT;
						state_q      <= ST_EMIT;
					end else begin
						pack_bits_q  <= pack_full[6:0];
						pack_count_q <= pack_count_q + 1'b1;
						if (enc_cnt_q == LEN_W'(1)) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_DEC_SHIFT: begin
					match_code_q <= {match_code_q[MAX_CODE_LEN-2:0], dec_bit};
					match_len_q  <= match_len_q + 1'b1;
					dec_byte_q   <= {dec_byte_q[6:0], 1'b0};
					dec_cnt_q    <= dec_cnt_q - 1'b1;
					scan_q       <= '0;
					state_q      <= ST_DEC_RD;
				end
				ST_DEC_RD: begin
					state_q <= ST_DEC_CMP;
				end
				ST_DEC_CMP: begin
					if (hit) begin
						match_code_q <= '0;
						match_len_q  <= '0;
						new_kind_q   <= hufc_pkg::KIND_SYMBOL;
						new_val_q    <= 8'(scan_q);
						ret_q        <= dec_next;
						state_q      <= ST_EMIT;
					end else if (!scan_last) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_DEC_RD;
					end else if (int'(match_len_q) >= MAX_CODE_LEN) begin
						match_code_q <= '0;
						match_len_q  <= '0;
						new_kind_q   <= hufc_pkg::KIND_ERROR;
						new_val_q    <= '0;
						ret_q        <= dec_next;
						state_q      <= ST_EMIT;
					end else begin
						state_q <= dec_next;
					end
				end
				ST_EMIT: begin
					// older result leaves as non-final, new one waits for its successor
					if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							out_kind_q <= pend_kind_q;
							out_val_q  <= pend_val_q;
							out_last_q <= 1'b0;
						end
						pend_vld_q  <= 1'b1;
						pend_kind_q <= new_kind_q;
						pend_val_q  <= new_val_q;
						state_q     <= ret_q;
					end
				end
				ST_FLUSH: begin
					// final result of the request carries tlast
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_kind_q <= pend_kind_q;
						out_val_q  <= pend_val_q;
						out_last_q <= 1'b1;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
